// ----- sv/srl_pkg.sv -----
// shared types, codes and helpers for the sorted record list
// no dependencies; imported by every module of the block
package srl_pkg;

    localparam int DEF_CAPACITY = 16;

    // one stored record
    typedef struct packed {
        logic [63:0]        key_head;
        logic [7:0]         key_tail;
        logic signed [31:0] number;
        logic [7:0]         term;
    } t_rec;

    // request codes
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SHOW   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4,
        ST_SHOWN     = 3'd5
    } t_status;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic cmp;  // latch compare flags against the new name
        logic ins;  // open a slot and insert
        logic del;  // close the gap at the first match
        logic rot;  // rotate the list one place towards cell zero
    } t_cell_ctl;

    // bring a request into stored form: bytes after the first zero byte read as zero
    function automatic t_rec canon_rec(input logic [63:0] head, input logic [7:0] tail,
                                       input logic signed [31:0] number,
                                       input logic [7:0] term);
        t_rec res;
        logic ended;
        ended = 1'b0;
        res.key_head = '0;
        for (int i = 7; i >= 0; i--) begin
            if (head[i*8 +: 8] == 8'd0)
                ended = 1'b1;
            if (!ended)
                res.key_head[i*8 +: 8] = head[i*8 +: 8];
        end
        res.key_tail = ended ? 8'd0 : tail;
        res.number   = number;
        res.term     = term;
        return res;
    endfunction

endpackage

// ----- sv/srl_cell.sv -----
// one cell of the sorted list: holds a record and its compare flags
// depends on srl_pkg
module srl_cell import srl_pkg::*; #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  t_rec             i_new,
    input  t_rec             i_left,
    input  t_rec             i_right,
    input  t_rec             i_head,
    input  logic             i_left_ge,
    output t_rec             o_rec,
    output logic             o_ge,
    output logic             o_hit
);

    localparam logic [CNT_W-1:0] C_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] C_NEXT = CNT_W'(IDX + 1);

    t_rec r_rec, n_rec;
    logic r_ge, r_eq;
    logic valid, at_pos, after_pos;

    assign valid = C_IDX < i_count;

    // ordered list: ge flags rise once along the chain and stay high
    assign at_pos    = ((valid && r_ge) || (C_IDX == i_count)) && !i_left_ge;
    assign after_pos = i_left_ge && (C_IDX <= i_count);

    // next record
    always_comb begin
        n_rec = r_rec;
        priority if (i_ctl.ins) begin
            if (after_pos)
                n_rec = i_left;
            else if (at_pos)
                n_rec = i_new;
        end else if (i_ctl.del) begin
            if (valid && r_ge && (C_NEXT < i_count))
                n_rec = i_right;
        end else if (i_ctl.rot) begin
            if (C_NEXT < i_count)
                n_rec = i_right;
            else if (C_NEXT == i_count)
                n_rec = i_head;
        end
    end

    // record and compare flags
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        if (i_ctl.cmp) begin
            r_ge <= {r_rec.key_head, r_rec.key_tail} >= {i_new.key_head, i_new.key_tail};
            r_eq <= {r_rec.key_head, r_rec.key_tail} == {i_new.key_head, i_new.key_tail};
        end
    end

    assign o_rec = r_rec;
    assign o_ge  = valid && r_ge;
    assign o_hit = valid && r_eq;

endmodule

// ----- sv/sorted_record_list.sv -----
// sorted record list: insert and delete run a compare state, then a shift state, then
// return to idle for the next request; the result is strobed together with the shifted list
// show streams one record a cycle from cell zero while the chain rotates, up to the last
// record; the receiver cannot stall; results come without back-pressure
// synchronous active-low reset empties the list and clears control; cells are not cleared
// depends on srl_pkg and srl_cell
module sorted_record_list import srl_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [63:0]        i_key_head,
    input  logic [7:0]         i_key_tail,
    input  logic signed [31:0] i_student_number,
    input  logic [7:0]         i_term,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic [63:0]        o_out_key_head,
    output logic [7:0]         o_out_key_tail,
    output logic signed [31:0] o_out_number,
    output logic [7:0]         o_out_term,
    output logic               o_final_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] C_CAP = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_SHOW
    } t_state;

    t_state           r_state;
    t_action          r_act;
    t_rec             r_new;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_strobe;
    t_status          r_status;
    t_rec             r_out;
    logic             r_final;

    t_cell_ctl        ctl;
    t_rec             w_rec [CAPACITY];
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_hit;
    logic             found;
    logic             accept;
    logic             last_show;

    assign accept    = start && (r_state == S_IDLE) && (t_action'(i_action) != ACT_NONE);
    assign found     = |w_hit;
    assign last_show = r_idx == r_count - CNT_W'(1);

    // command to the chain
    always_comb begin
        ctl.cmp = r_state == S_CMP;
        ctl.ins = (r_state == S_EXEC) && (r_act == ACT_INSERT) && (r_count != C_CAP);
        ctl.del = (r_state == S_EXEC) && (r_act == ACT_DELETE) && found;
        ctl.rot = r_state == S_SHOW;
    end

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_rec left_rec, right_rec;
        logic left_ge;
        if (g == 0) begin : g_first
            assign left_rec = w_rec[g];
            assign left_ge  = 1'b0;
        end else begin : g_inner
            assign left_rec = w_rec[g-1];
            assign left_ge  = w_ge[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_rec = w_rec[g];
        end else begin : g_body
            assign right_rec = w_rec[g+1];
        end
        srl_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_count   (r_count),
            .i_new     (r_new),
            .i_left    (left_rec),
            .i_right   (right_rec),
            .i_head    (w_rec[0]),
            .i_left_ge (left_ge),
            .o_rec     (w_rec[g]),
            .o_ge      (w_ge[g]),
            .o_hit     (w_hit[g])
        );
    end

    // sequencer and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act   <= t_action'(i_action);
                        r_new   <= canon_rec(i_key_head, i_key_tail, i_student_number, i_term);
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_idx <= '0;
                    if (r_act == ACT_SHOW && r_count != '0)
                        r_state <= S_SHOW;
                    else
                        r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_strobe <= 1'b1;
                    r_final  <= 1'b1;
                    r_out    <= '0;
                    r_state  <= S_IDLE;
                    unique case (r_act)
                        ACT_INSERT: begin
                            if (r_count == C_CAP) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_INSERTED;
                                r_count  <= r_count + CNT_W'(1);
                            end
                        end
                        ACT_DELETE: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                            end else if (found) begin
                                r_status <= ST_DELETED;
                                r_count  <= r_count - CNT_W'(1);
                            end else begin
                                r_status <= ST_NOT_FOUND;
                            end
                        end
                        default: r_status <= ST_EMPTY;
                    endcase
                end
                S_SHOW: begin
                    r_strobe <= 1'b1;
                    r_status <= ST_SHOWN;
                    r_out    <= w_rec[0];
                    r_final  <= last_show;
                    r_idx    <= r_idx + CNT_W'(1);
                    if (last_show)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = r_state != S_IDLE;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_key_head = r_out.key_head;
    assign o_out_key_tail = r_out.key_tail;
    assign o_out_number   = r_out.number;
    assign o_out_term     = r_out.term;
    assign o_final_res    = r_final;

endmodule

// ----- sv/srl_checker.sv -----
// port-level checks for the sorted record list, bound to the top level
// depends on srl_pkg and sorted_record_list
module srl_checker import srl_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_action,
    input logic               o_strobe,
    input logic [2:0]         o_status,
    input logic [63:0]        o_out_key_head,
    input logic [7:0]         o_out_key_tail,
    input logic signed [31:0] o_out_number,
    input logic [7:0]         o_out_term,
    input logic               o_final_res
);

    // reset leaves the block idle and quiet
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("block not idle after reset");

    // a real request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_action != ACT_NONE) |=> busy)
        else $error("request accepted without going busy");

    // a show stream has no gaps until its last record
    a_stream_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_final_res |=> o_strobe && (o_status == ST_SHOWN))
        else $error("show stream broken before its last record");

    // single results carry zero payload and close the request
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_SHOWN) |-> o_final_res && (o_out_key_head == '0)
            && (o_out_key_tail == '0) && (o_out_number == '0) && (o_out_term == '0))
        else $error("malformed single result");

    // nothing follows the last result of a request in the next cycle
    a_final_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_final_res |=> !o_strobe)
        else $error("result after the final one");

endmodule

bind sorted_record_list srl_checker u_srl_checker (.*);
